/* src/itrs_pkg.sv */
package itrs_pkg;

  // Default and fixed widths
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned RAW_W          = 64;
  localparam int unsigned FUNC_W         = 2;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned DIGIT_W        = 6;
  localparam int unsigned CHAR_W         = 7;

  // Quotient bits resolved by the divider in each cycle
  localparam int unsigned DIV_BITS_PER_CYCLE = 8;

  // Number kinds carried in the func field
  localparam logic [FUNC_W-1:0] FUNC_S32  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_S64  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_U32  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_U64  = 2'd3;

  // Radix limits
  localparam logic [RADIX_W-1:0] MIN_RADIX     = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX     = 6'd36;
  localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 6'd10;

  // ASCII anchors
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] DECIMAL_TEN  = 7'd10;

  typedef struct packed {
    logic [RAW_W-1:0]   value;
    logic [FUNC_W-1:0]  func;
    logic [RADIX_W-1:0] radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              is_negative;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FETCH,
    ST_SEND
  } itrs_state_e;

  // Map a digit value 0..35 to its lower-case ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (dx < DECIMAL_TEN) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_LOWER_A + dx - DECIMAL_TEN;
  endfunction

endpackage

/* src/itrs_div.sv */
module itrs_div #(
  parameter int unsigned PAD_BITS = itrs_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [PAD_BITS-1:0]          dividend_i,
  input  logic [itrs_pkg::DIGIT_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [PAD_BITS-1:0]          quot_o,
  output logic [itrs_pkg::DIGIT_W-1:0] rem_o
);
  import itrs_pkg::*;

  localparam int unsigned BPC    = DIV_BITS_PER_CYCLE;
  localparam int unsigned STEPS  = PAD_BITS / BPC;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                run_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [PAD_BITS-1:0] work_q;
  logic [DIGIT_W-1:0]  rem_q;
  logic [DIGIT_W-1:0]  divisor_q;

  logic [BPC-1:0]      qbits;
  logic [DIGIT_W-1:0]  rem_d;

  // Resolve BPC restoring-division steps on the narrow partial remainder
  always_comb begin
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] r;
    r     = rem_q;
    qbits = '0;
    for (int unsigned i = 0; i < BPC; i++) begin
      trial = {r, work_q[PAD_BITS-1-i]};
      if (trial >= {1'b0, divisor_q}) begin
        trial            = trial - {1'b0, divisor_q};
        qbits[BPC-1-i]   = 1'b1;
      end
      r = trial[DIGIT_W-1:0];
    end
    rem_d = r;
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in as dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (run_q) begin
      work_q <= {work_q[PAD_BITS-BPC-1:0], qbits};
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q;
  assign rem_o  = rem_q;

endmodule

/* src/integer_to_radix_string.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | in_data_i  (value, func, radix)
// out     | output    | out_valid_o / out_stall_i | out_data_o (digit_char, is_negative, last)
//
// Each digit of an item costs one pass of the shared divider, at 8 quotient bits per
// cycle plus start and done, then a read back from the digit store (ST_FETCH) and its
// presentation on the output (ST_SEND). A 64-bit decimal value has up to 20 digits.
// Reset clears the sequencer; the block takes the next item only after the last digit.
// An output stall holds the current digit and the sequence until the transfer completes.
module integer_to_radix_string #(
  parameter int unsigned VALUE_BITS = itrs_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itrs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itrs_pkg::out_item_t out_data_o
);
  import itrs_pkg::*;

  localparam int unsigned BPC      = DIV_BITS_PER_CYCLE;
  localparam int unsigned PAD_BITS = ((VALUE_BITS + BPC - 1) / BPC) * BPC;
  localparam int unsigned CNT_W    = $clog2(VALUE_BITS + 1);
  localparam int unsigned IDX_W    = $clog2(VALUE_BITS);

  itrs_state_e state_q, state_d;

  logic [PAD_BITS-1:0] mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [RADIX_W-1:0]  base_q, base_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic                div_start;
  logic                div_done;
  logic [PAD_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]  div_rem;

  logic                mem_we;
  logic                mem_re;
  logic [CNT_W-1:0]    cnt_m1;
  logic [DIGIT_W-1:0]  digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]  rd_q;

  logic                is_narrow;
  logic                is_signed;
  logic                sign_bit;
  logic [VALUE_BITS-1:0] sel_val;
  logic [VALUE_BITS-1:0] abs_val;
  logic [31:0]           neg32;
  logic [VALUE_BITS-1:0] negw;
  logic [RADIX_W-1:0]    radix_n;

  assign cnt_m1  = cnt_q - 1'b1;

  // Pick the active width, take the magnitude and default an out-of-range radix
  always_comb begin
    is_narrow = in_data_i.func inside {FUNC_S32, FUNC_U32};
    is_signed = in_data_i.func inside {FUNC_S32, FUNC_S64};
    sel_val   = is_narrow ? VALUE_BITS'(in_data_i.value[31:0])
                          : in_data_i.value[VALUE_BITS-1:0];
    sign_bit  = is_narrow ? in_data_i.value[31] : in_data_i.value[VALUE_BITS-1];
    neg32     = 32'd0 - in_data_i.value[31:0];
    negw      = '0 - sel_val;
    if (is_signed && sign_bit) begin
      abs_val = is_narrow ? VALUE_BITS'(neg32) : negw;
    end else begin
      abs_val = sel_val;
    end
    radix_n = (in_data_i.radix < MIN_RADIX || in_data_i.radix > MAX_RADIX)
              ? DEFAULT_RADIX : in_data_i.radix;
  end

  // Shared divider
  itrs_div #(
    .PAD_BITS (PAD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (base_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    base_q <= base_d;
  end

  // Sequence divisions, then read the digits back most significant first
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    base_d      = base_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          mag_d   = PAD_BITS'(abs_val);
          neg_d   = is_signed && sign_bit;
          base_d  = radix_n;
          cnt_d   = '0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          mag_d  = div_quot;
          state_d = (div_quot == '0) ? ST_FETCH : ST_START;
        end
      end
      ST_FETCH: begin
        mem_re  = 1'b1;
        cnt_d   = cnt_m1;
        state_d = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = (cnt_q == '0) ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Digit store: push remainders, pop in reverse order
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[IDX_W-1:0]] <= div_rem;
    end
    if (mem_re) begin
      rd_q <= digit_mem[cnt_m1[IDX_W-1:0]];
    end
  end

  // Present the popped digit
  always_comb begin
    out_data_o.digit_char  = digit_to_char(rd_q);
    out_data_o.is_negative = neg_q;
    out_data_o.last        = (cnt_q == '0);
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import itrs_pkg::*;

  localparam int unsigned VALUE_BITS     = VALUE_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_OFF_LEN   = 600;
  localparam int unsigned TAIL_CYCLES    = 100;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Characters still owed by the block, oldest first
  out_item_t   expected_chars[$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit          sender_idle_en;
  bit          sink_idle_en;
  int unsigned hold_off_req;

  integer_to_radix_string #(
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the digit characters for one number, most significant first
  task automatic predict_digits(input in_item_t item);
    logic [63:0]      mag;
    logic [63:0]      mask;
    logic [63:0]      base;
    logic [63:0]      rem;
    int unsigned      width;
    bit               neg;
    bit               is_signed;
    logic [CHAR_W-1:0] chars[$];
    out_item_t        r;
    base = 64'(item.radix);
    if (item.radix < MIN_RADIX || item.radix > MAX_RADIX) begin
      base = 64'(DEFAULT_RADIX);
    end
    width = (item.func == FUNC_S64 || item.func == FUNC_U64) ? VALUE_BITS : 32;
    is_signed = (item.func == FUNC_S32 || item.func == FUNC_S64);
    mask = {64{1'b1}} >> (64 - width);
    mag = item.value & mask;
    neg = 1'b0;
    if (is_signed && mag[width-1]) begin
      neg = 1'b1;
      mag = (~mag + 64'd1) & mask;
    end
    while (mag != 64'd0) begin
      rem = mag % base;
      if (rem < 64'(DECIMAL_TEN)) begin
        chars.push_front(CHAR_ZERO + CHAR_W'(rem));
      end else begin
        chars.push_front(CHAR_LOWER_A + CHAR_W'(rem) - DECIMAL_TEN);
      end
      mag = mag / base;
    end
    if (chars.size() == 0) begin
      chars.push_front(CHAR_ZERO);
    end
    foreach (chars[i]) begin
      r.digit_char  = chars[i];
      r.is_negative = neg;
      r.last        = (i == chars.size() - 1);
      expected_chars.insert(expected_chars.size(), r);
    end
  endtask

  // Offer one number and hold it until the transfer; leaves valid high unless a gap follows
  task automatic send_number(input logic [63:0] v, input logic [FUNC_W-1:0] f,
                             input logic [RADIX_W-1:0] rdx);
    in_item_t item;
    item.value = v;
    item.func  = f;
    item.radix = rdx;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_digits(item);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drop valid after the last number of a sequence
  task automatic park_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Random value with a spread of digit counts, signs and junk in the upper word
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom} >> $urandom_range(0, 63);
    if ($urandom_range(0, 1) == 1) begin
      v = ~v + 64'd1;
    end
    if ($urandom_range(0, 3) == 0) begin
      v[63:32] = $urandom;
    end
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 1) == 1) begin
      return RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
    end
    return RADIX_W'($urandom_range(0, 63));
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      send_number(pick_value(), FUNC_W'($urandom_range(0, 3)), pick_radix());
    end
    park_input();
  endtask

  // Extremes, every kind, out-of-range radixes and the most negative values
  task automatic test_directed();
    send_number(64'd0, FUNC_U32, 6'd10);
    send_number(64'd0, FUNC_S64, 6'd2);
    send_number(64'hFFFF_FFFF, FUNC_U32, 6'd16);
    send_number({64{1'b1}}, FUNC_U64, 6'd2);
    send_number({64{1'b1}}, FUNC_U64, 6'd36);
    send_number(64'h8000_0000, FUNC_S32, 6'd10);
    send_number(64'h8000_0000_0000_0000, FUNC_S64, 6'd10);
    send_number(64'h8000_0000_0000_0000, FUNC_S64, 6'd2);
    send_number({64{1'b1}}, FUNC_S32, 6'd10);
    send_number({64{1'b1}}, FUNC_S64, 6'd7);
    send_number(64'h7FFF_FFFF, FUNC_S32, 6'd36);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, FUNC_S64, 6'd16);
    send_number(64'd123456789, FUNC_U32, 6'd0);
    send_number(64'd123456789, FUNC_U32, 6'd1);
    send_number(64'd123456789, FUNC_U32, 6'd37);
    send_number(64'd123456789, FUNC_U32, 6'd63);
    send_number(64'd35, FUNC_U32, 6'd36);
    send_number(64'd36, FUNC_U64, 6'd36);
    send_number(64'hDEAD_BEEF_0000_002A, FUNC_U32, 6'd10);
    send_number(64'hFFFF_FFFF_8000_0001, FUNC_S32, 6'd3);
    send_number(64'h0123_4567_89AB_CDEF, FUNC_U64, 6'd16);
    send_number(64'd9, FUNC_S64, 6'd10);
    send_number(64'hAAAA_AAAA_5555_5555, FUNC_S32, 6'd35);
    park_input();
  endtask

  // Hold off the output so the block backs up and stalls its input
  task automatic test_output_hold_off();
    hold_off_req = HOLD_OFF_LEN;
    send_random(8);
  endtask

  // Let every pending character arrive before the next batch
  task automatic test_drain_pause();
    send_random(5);
    wait_drained();
    send_random(5);
  endtask

  task automatic test_random_mix();
    send_random(160);
  endtask

  // Back to back on both sides
  task automatic test_full_rate();
    wait_drained();
    sender_idle_en = 1'b0;
    sink_idle_en   = 1'b0;
    send_random(20);
  endtask

  // Output side: random stall bursts, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_req) @(posedge clk);
        hold_off_req = 0;
        out_stall <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each character transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %h", $realtime, out_data);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.digit_char !== want.digit_char) begin
          $display("%0t: digit_char mismatch, expected %h, got %h", $realtime,
                   want.digit_char, out_data.digit_char);
          error_count++;
        end
        if (out_data.is_negative !== want.is_negative) begin
          $display("%0t: is_negative mismatch, expected %b, got %b", $realtime,
                   want.is_negative, out_data.is_negative);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch, expected %b, got %b", $realtime,
                   want.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("integer_to_radix_string regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    error_count    = 0;
    quiet_cycles   = 0;
    hold_off_req   = 0;
    sender_idle_en = 1'b1;
    sink_idle_en   = 1'b1;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_output_hold_off();
    test_drain_pause();
    test_random_mix();
    test_full_rate();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("integer_to_radix_string regression: pass");
    end else begin
      $display("integer_to_radix_string regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/itrs_pkg.sv
src/itrs_div.sv
src/integer_to_radix_string.sv
tb/sv/tb.sv
